@@ sv/u8250_pkg.sv @@
// Shared types and constants for the 8250-style UART register unit.
// Depends on nothing; the top level refers to it by scoped names.
package u8250_pkg;

    // FIFO geometry.
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    // Level marks: full, and the overrun mark one below full.
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);
    localparam logic [LVL_W-1:0] LVL_OVR  = LVL_W'(FIFO_DEPTH - 1);

    // Item kinds.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_RECV  = 2'd3;

    // Register offsets.
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;

    // Fixed values and reset values.
    localparam logic [7:0] IIR_FIXED = 8'hc1;
    localparam logic [7:0] FCR_RESET = 8'hc0;
    localparam logic [7:0] LCR_RESET = 8'h03;
    localparam logic [3:0] IER_MASK  = 4'hf;

    // Bit positions.
    localparam int LCR_DLAB   = 7;
    localparam int MCR_LOOP   = 4;
    localparam int FCR_RXCLR  = 1;
    localparam int FCR_TXCLR  = 2;
    localparam int LSR_DR     = 0;
    localparam int LSR_OE     = 1;
    localparam int LSR_THRE   = 5;
    localparam int LSR_TEMT   = 6;

    // One input item.
    typedef struct packed {
        logic [1:0] func;
        logic [2:0] offset;
        logic [7:0] data_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] line_status;
    } t_out_item;

endpackage

@@ sv/uart_8250_register_model_unit.sv @@
// Top level of the 8250-style UART register unit: register file, divisor
// counter and the transmit and receive FIFOs. Depends on u8250_pkg.

// An item is registered when accepted and then applied to the UART state, and its
// result is registered; the item waits while the result register is blocked. One
// item is taken per cycle without gaps while the output does not stall: all state
// (registers, ring pointers and fill levels of both 16-entry FIFOs) is updated
// by one short combinational pass per item. The input stalls only while both the
// item register and the result register are full and the output is stalled; that
// output stall reaches o_in_stall in the same cycle. Both FIFOs are rings with a
// head pointer and a level; nothing needs clearing after reset.
module uart_8250_register_model_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  u8250_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output u8250_pkg::t_out_item  o_out_item
);

    // Pipeline registers.
    logic                    r_item_valid;
    u8250_pkg::t_in_item     r_item;
    logic                    r_res_valid;
    u8250_pkg::t_out_item    r_res;
    u8250_pkg::t_out_item    n_res;

    // UART state.
    logic [3:0]  r_ier, n_ier;
    logic [7:0]  r_fcr, n_fcr;
    logic [7:0]  r_lcr, n_lcr;
    logic [7:0]  r_mcr, n_mcr;
    logic [7:0]  r_lsr, n_lsr;
    logic [7:0]  r_msr, n_msr;
    logic [15:0] r_div, n_div;
    logic [15:0] r_tick, n_tick;

    logic [u8250_pkg::PTR_W-1:0] r_tx_head, n_tx_head;
    logic [u8250_pkg::LVL_W-1:0] r_tx_level, n_tx_level;
    logic [u8250_pkg::PTR_W-1:0] r_rx_head, n_rx_head;
    logic [u8250_pkg::LVL_W-1:0] r_rx_level, n_rx_level;

    // FIFO storage, no reset.
    logic [7:0] r_tx_mem [u8250_pkg::FIFO_DEPTH];
    logic [7:0] r_rx_mem [u8250_pkg::FIFO_DEPTH];

    // Write ports of the FIFO storage.
    logic                        tx_we, rx_we;
    logic [u8250_pkg::PTR_W-1:0] tx_waddr, rx_waddr;
    logic [7:0]                  tx_wdata, rx_wdata;

    // Receive request, from the line or from loopback.
    logic       rx_push;
    logic [7:0] rx_byte;
    logic [7:0] tx_head_byte;

    logic in_take;
    logic res_free;
    logic process;

    // Advance a ring pointer by one.
    function automatic logic [u8250_pkg::PTR_W-1:0] ptr_inc(
        input logic [u8250_pkg::PTR_W-1:0] p
    );
        logic [u8250_pkg::PTR_W-1:0] r;
        if (p == u8250_pkg::PTR_W'(u8250_pkg::FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Tail slot of a ring: head plus level, wrapped once.
    function automatic logic [u8250_pkg::PTR_W-1:0] ptr_tail(
        input logic [u8250_pkg::PTR_W-1:0] p,
        input logic [u8250_pkg::LVL_W-1:0] lvl
    );
        logic [u8250_pkg::LVL_W:0] s;
        s = (u8250_pkg::LVL_W+1)'(p) + (u8250_pkg::LVL_W+1)'(lvl);
        if (s >= (u8250_pkg::LVL_W+1)'(u8250_pkg::FIFO_DEPTH)) begin
            s = s - (u8250_pkg::LVL_W+1)'(u8250_pkg::FIFO_DEPTH);
        end
        return s[u8250_pkg::PTR_W-1:0];
    endfunction

    // Handshake: the item register holds while the result register is blocked.
    assign res_free    = !r_res_valid || !i_out_stall;
    assign process     = r_item_valid && res_free;
    assign o_in_stall  = r_item_valid && !res_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_res_valid;
    assign o_out_item  = r_res;

    assign tx_head_byte = r_tx_mem[r_tx_head];

    // Single pass of the register model over the current item.
    always_comb begin
        n_ier      = r_ier;
        n_fcr      = r_fcr;
        n_lcr      = r_lcr;
        n_mcr      = r_mcr;
        n_lsr      = r_lsr;
        n_msr      = r_msr;
        n_div      = r_div;
        n_tick     = r_tick;
        n_tx_head  = r_tx_head;
        n_tx_level = r_tx_level;
        n_rx_head  = r_rx_head;
        n_rx_level = r_rx_level;
        tx_we      = 1'b0;
        tx_waddr   = ptr_tail(r_tx_head, r_tx_level);
        tx_wdata   = r_item.data_in;
        rx_we      = 1'b0;
        rx_waddr   = ptr_tail(r_rx_head, r_rx_level);
        rx_wdata   = '0;
        rx_push    = 1'b0;
        rx_byte    = r_item.data_in;
        n_res      = '0;

        case (r_item.func)
            u8250_pkg::FUNC_READ: begin
                case (r_item.offset)
                    u8250_pkg::REG_DATA: begin
                        if (r_lcr[u8250_pkg::LCR_DLAB]) begin
                            n_res.read_data = r_div[7:0];
                        end else begin
                            if (r_rx_level != '0) begin
                                n_res.read_data = r_rx_mem[r_rx_head];
                                n_rx_head       = ptr_inc(r_rx_head);
                                n_rx_level      = r_rx_level - 1'b1;
                            end
                            // Data ready drops once the FIFO has run empty.
                            if (r_rx_level <= u8250_pkg::LVL_W'(1)) begin
                                n_lsr[u8250_pkg::LSR_DR] = 1'b0;
                            end
                        end
                    end
                    u8250_pkg::REG_IER: begin
                        if (r_lcr[u8250_pkg::LCR_DLAB]) begin
                            n_res.read_data = r_div[15:8];
                        end else begin
                            n_res.read_data = {4'b0, r_ier};
                        end
                    end
                    u8250_pkg::REG_IIR: n_res.read_data = u8250_pkg::IIR_FIXED;
                    u8250_pkg::REG_LCR: n_res.read_data = r_lcr;
                    u8250_pkg::REG_LSR: begin
                        n_res.read_data          = r_lsr;
                        n_lsr[u8250_pkg::LSR_OE] = 1'b0;
                    end
                    u8250_pkg::REG_MSR: n_res.read_data = r_msr;
                    default:            n_res.read_data = '0;
                endcase
            end
            u8250_pkg::FUNC_WRITE: begin
                case (r_item.offset)
                    u8250_pkg::REG_DATA: begin
                        if (r_lcr[u8250_pkg::LCR_DLAB]) begin
                            n_div[7:0] = r_item.data_in;
                        end else if (r_tx_level < u8250_pkg::LVL_FULL) begin
                            tx_we                      = 1'b1;
                            n_tx_level                 = r_tx_level + 1'b1;
                            n_lsr[u8250_pkg::LSR_THRE] = 1'b0;
                            n_lsr[u8250_pkg::LSR_TEMT] = 1'b0;
                        end
                    end
                    u8250_pkg::REG_IER: begin
                        if (r_lcr[u8250_pkg::LCR_DLAB]) begin
                            n_div[15:8] = r_item.data_in;
                        end else begin
                            n_ier = r_item.data_in[3:0] & u8250_pkg::IER_MASK;
                        end
                    end
                    u8250_pkg::REG_IIR: begin
                        // FCR: the clear bits flush the FIFOs.
                        n_fcr = r_item.data_in;
                        if (r_item.data_in[u8250_pkg::FCR_RXCLR]) begin
                            n_rx_level               = '0;
                            n_lsr[u8250_pkg::LSR_DR] = 1'b0;
                        end
                        if (r_item.data_in[u8250_pkg::FCR_TXCLR]) begin
                            n_tx_level = '0;
                        end
                    end
                    u8250_pkg::REG_LCR: n_lcr = r_item.data_in;
                    u8250_pkg::REG_MCR: begin
                        n_mcr = r_item.data_in;
                        if (r_item.data_in[u8250_pkg::MCR_LOOP]) begin
                            // Loopback mirrors the modem outputs onto the inputs.
                            n_msr[7] = r_item.data_in[3];
                            n_msr[6] = r_item.data_in[2];
                            n_msr[4] = r_item.data_in[1];
                            n_msr[5] = r_item.data_in[0];
                        end else begin
                            n_msr[7:6] = 2'b00;
                        end
                    end
                    default: ;
                endcase
            end
            u8250_pkg::FUNC_TICK: begin
                if (r_tick >= r_div) begin
                    n_tick = '0;
                    if (r_tx_level != '0) begin
                        n_tx_head  = ptr_inc(r_tx_head);
                        n_tx_level = r_tx_level - 1'b1;
                        if (r_mcr[u8250_pkg::MCR_LOOP]) begin
                            rx_push = 1'b1;
                            rx_byte = tx_head_byte;
                        end else begin
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = tx_head_byte;
                        end
                        if (r_tx_level == u8250_pkg::LVL_W'(1)) begin
                            n_lsr[u8250_pkg::LSR_TEMT] = 1'b1;
                        end
                    end
                    if (r_tx_level <= u8250_pkg::LVL_W'(1)) begin
                        n_lsr[u8250_pkg::LSR_THRE] = 1'b1;
                    end
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            default: begin
                rx_push = 1'b1;
            end
        endcase

        // Receive path; an almost full FIFO drops the byte and flags overrun.
        if (rx_push) begin
            if (r_rx_level >= u8250_pkg::LVL_OVR) begin
                n_lsr[u8250_pkg::LSR_OE] = 1'b1;
            end else begin
                rx_we      = 1'b1;
                rx_wdata   = rx_byte;
                n_rx_level = r_rx_level + 1'b1;
            end
            n_lsr[u8250_pkg::LSR_DR] = (n_rx_level != '0);
        end

        n_res.line_status = n_lsr;
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_res_valid  <= 1'b0;
            r_ier        <= '0;
            r_fcr        <= u8250_pkg::FCR_RESET;
            r_lcr        <= u8250_pkg::LCR_RESET;
            r_mcr        <= '0;
            r_lsr        <= '0;
            r_msr        <= '0;
            r_div        <= '0;
            r_tick       <= '0;
            r_tx_head    <= '0;
            r_tx_level   <= '0;
            r_rx_head    <= '0;
            r_rx_level   <= '0;
        end else begin
            r_item_valid <= in_take || (r_item_valid && !process);
            if (process) begin
                r_res_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_res_valid <= 1'b0;
            end
            if (process) begin
                r_ier      <= n_ier;
                r_fcr      <= n_fcr;
                r_lcr      <= n_lcr;
                r_mcr      <= n_mcr;
                r_lsr      <= n_lsr;
                r_msr      <= n_msr;
                r_div      <= n_div;
                r_tick     <= n_tick;
                r_tx_head  <= n_tx_head;
                r_tx_level <= n_tx_level;
                r_rx_head  <= n_rx_head;
                r_rx_level <= n_rx_level;
            end
        end
    end

    // Payload registers and FIFO storage.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_item;
        end
        if (process) begin
            r_res <= n_res;
            if (tx_we) begin
                r_tx_mem[tx_waddr] <= tx_wdata;
            end
            if (rx_we) begin
                r_rx_mem[rx_waddr] <= rx_wdata;
            end
        end
    end

endmodule
